>>> rtl/core/lxc_pkg.sv
package lxc_pkg;

  localparam int TABLE_DEPTH = 512;

  localparam int HALF_DEPTH = TABLE_DEPTH / 2;
  localparam int BANK_ROWS  = (TABLE_DEPTH + 1) / 2;
  localparam int ROW_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
  localparam int SLOT_W     = $clog2(TABLE_DEPTH);
  localparam int IDX_W      = $clog2(HALF_DEPTH + 1);

  localparam int SEED_W = 31;
  localparam int TMAX_W = 15;
  localparam int PROD_W = SEED_W + TMAX_W;

  localparam logic [SEED_W-1:0] PM_MOD     = 31'h7fff_ffff;
  localparam logic [TMAX_W-1:0] PM_MUL     = 15'd16807;
  localparam logic [SEED_W-1:0] SEED_RESET = 31'd666666;
  localparam logic [TMAX_W-1:0] TMAX_RESET = 15'd256;

  localparam logic [1:0] CMD_BUILD = 2'd0;
  localparam logic [1:0] CMD_ENC   = 2'd1;
  localparam logic [1:0] CMD_DEC   = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_UNBUILT = 2'd1;
  localparam logic [1:0] STS_LONG    = 2'd2;

  localparam logic CFG_SEED = 1'b0;
  localparam logic CFG_TMAX = 1'b1;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } key_wr_t;

  typedef enum logic [2:0] {
    KG_IDLE,
    KG_MUL,
    KG_RED,
    KG_SCL,
    KG_WR
  } kg_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_BUILD
  } core_state_t;

endpackage

>>> rtl/core/lxc_key_bank.sv
module lxc_key_bank
  import lxc_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [ROW_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [ROW_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [BANK_ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/lxc_keygen.sv
module lxc_keygen
  import lxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SEED_W-1:0] seed_value,
  input  logic [TMAX_W-1:0] table_max,
  output key_wr_t           wr,
  output logic              done
);

  kg_state_t         state;
  kg_state_t         state_next;
  logic [SEED_W-1:0] pm_state;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;
  logic [SLOT_W-1:0] slot;

  logic [SEED_W:0]   red_sum;
  logic [SEED_W:0]   red_fix;
  logic [SEED_W-1:0] red_out;
  logic [SEED_W:0]   scl_rem;
  logic [7:0]        scl_byte;
  logic              last_slot;

  assign last_slot = (slot == '0);

  // Mersenne reduction of 16807 * s; zero only for s = 2^31-1, which sticks
  always_comb begin
    red_sum = {1'b0, prod[SEED_W-1:0]} + (SEED_W + 1)'(prod[PROD_W-1:SEED_W]);
    red_fix = (red_sum >= {1'b0, PM_MOD}) ? red_sum - {1'b0, PM_MOD} : red_sum;
    red_out = (red_fix == '0) ? PM_MOD : red_fix[SEED_W-1:0];
  end

  // floor(s * table_max / (2^31-1)), low byte only
  always_comb begin
    scl_rem  = {1'b0, scaled[SEED_W-1:0]} + (SEED_W + 1)'(scaled[PROD_W-1:SEED_W]);
    scl_byte = scaled[SEED_W+7:SEED_W] + 8'(scl_rem >= {1'b0, PM_MOD});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      KG_IDLE: if (start) state_next = KG_MUL;
      KG_MUL:  state_next = KG_RED;
      KG_RED:  state_next = KG_SCL;
      KG_SCL:  state_next = KG_WR;
      KG_WR:   state_next = last_slot ? KG_IDLE : KG_RED;
      default: state_next = KG_IDLE;
    endcase
  end

  always_comb begin
    wr.we   = (state == KG_WR);
    wr.slot = slot;
    wr.data = scl_byte;
    done    = (state == KG_WR) && last_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= KG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      KG_IDLE: begin
        pm_state <= (seed_value == '0) ? SEED_W'(1) : seed_value;
        slot     <= SLOT_W'(TABLE_DEPTH - 1);
      end
      KG_MUL: prod <= pm_state * PM_MUL;
      KG_RED: pm_state <= red_out;
      KG_SCL: scaled <= pm_state * table_max;
      KG_WR: begin
        prod <= pm_state * PM_MUL;
        slot <= slot - SLOT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/lut_xor_chain_cipher_core.sv
// Encrypt and decrypt: an accepted word and both key-bank reads are registered; the
// result is registered onto m_axis_tvalid once the output is free, and a new word is
// taken only after it is loaded. Rebuild: the Park-Miller step and the scaling run
// through KG_RED, KG_SCL and KG_WR per table slot. Rebuild answers with a zero word.
// Synchronous active-high reset clears control state, chain and index; the key table
// holds no reset value and reads as unbuilt until the first rebuild.
module lut_xor_chain_cipher_core
  import lxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [SEED_W-1:0] cfg_data,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // in_byte
  input  logic [2:0]        s_axis_tuser,  // command[1:0], first[2]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,  // out_byte
  output logic [1:0]        m_axis_tuser   // status[1:0]
);

  core_state_t       state;
  core_state_t       state_next;
  logic [SEED_W-1:0] seed_value;
  logic [TMAX_W-1:0] table_max;
  logic              table_built;
  logic [IDX_W-1:0]  key_index;
  logic [7:0]        chain_byte;
  logic [1:0]        cmd_q;
  logic [7:0]        byte_q;
  logic              first_q;

  logic              accept;
  logic              kg_start;
  logic              kg_done;
  key_wr_t           kg_wr;
  logic              out_load;
  logic [IDX_W-1:0]  rd_index;
  logic [7:0]        k_even;
  logic [7:0]        k_odd;

  logic [IDX_W-1:0]  idx_eff;
  logic [7:0]        chain_eff;
  logic              in_range;
  logic              is_xcode;
  logic [7:0]        res_byte;
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  key_index_next;
  logic [7:0]        chain_byte_next;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign rd_index  = s_axis_tuser[2] ? '0 : key_index;

  lxc_keygen u_keygen (
    .clk        (clk),
    .rst        (rst),
    .start      (kg_start),
    .seed_value (seed_value),
    .table_max  (table_max),
    .wr         (kg_wr),
    .done       (kg_done)
  );

  lxc_key_bank u_bank_even (
    .clk   (clk),
    .we    (kg_wr.we && !kg_wr.slot[0]),
    .waddr (ROW_W'(kg_wr.slot >> 1)),
    .wdata (kg_wr.data),
    .re    (accept),
    .raddr (ROW_W'(rd_index)),
    .rdata (k_even)
  );

  lxc_key_bank u_bank_odd (
    .clk   (clk),
    .we    (kg_wr.we && kg_wr.slot[0]),
    .waddr (ROW_W'(kg_wr.slot >> 1)),
    .wdata (kg_wr.data),
    .re    (accept),
    .raddr (ROW_W'(rd_index)),
    .rdata (k_odd)
  );

  always_comb begin
    idx_eff         = first_q ? '0 : key_index;
    chain_eff       = first_q ? '0 : chain_byte;
    in_range        = (idx_eff < IDX_W'(HALF_DEPTH));
    is_xcode        = (cmd_q == CMD_ENC) || (cmd_q == CMD_DEC);
    res_byte        = 8'h00;
    res_status      = STS_OK;
    key_index_next  = key_index;
    chain_byte_next = chain_byte;
    if (is_xcode) begin
      key_index_next  = idx_eff;
      chain_byte_next = chain_eff;
      if (!table_built) begin
        res_status = STS_UNBUILT;
      end else if (!in_range) begin
        res_status = STS_LONG;
      end else begin
        res_byte        = byte_q ^ k_even ^ chain_eff;
        chain_byte_next = ((cmd_q == CMD_ENC) ? res_byte : byte_q) ^ k_odd;
        key_index_next  = idx_eff + IDX_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (accept) begin
          state_next = (s_axis_tuser[1:0] == CMD_BUILD) ? CS_BUILD : CS_EXEC;
        end
      end
      CS_BUILD: if (kg_done) state_next = CS_EXEC;
      CS_EXEC:  if (out_load) state_next = CS_IDLE;
      default:  state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == CS_IDLE);
    kg_start      = accept && (s_axis_tuser[1:0] == CMD_BUILD);
    out_load      = (state == CS_EXEC) && (!m_axis_tvalid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      seed_value    <= SEED_RESET;
      table_max     <= TMAX_RESET;
      table_built   <= 1'b0;
      key_index     <= '0;
      chain_byte    <= 8'h00;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SEED: seed_value <= cfg_data;
          CFG_TMAX: table_max  <= cfg_data[TMAX_W-1:0];
          default:  ;
        endcase
      end
      if (kg_done) begin
        table_built <= 1'b1;
      end
      if (out_load) begin
        key_index     <= key_index_next;
        chain_byte    <= chain_byte_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= s_axis_tuser[1:0];
      first_q <= s_axis_tuser[2];
      byte_q  <= s_axis_tdata;
    end
    if (out_load) begin
      m_axis_tdata <= res_byte;
      m_axis_tuser <= res_status;
    end
  end

endmodule
